[hdl/nfba_pkg.sv]
// ----------------------------------------------------------------------------
// nfba_pkg: shared types and constants of the next-fit block allocator
// Bitmap geometry, command codes, controller states and the word-scan result.
// ----------------------------------------------------------------------------
package nfba_pkg;

   localparam int ID_W       = 10;
   localparam int ID_SPACE   = 1 << ID_W;
   localparam int NUM_BLOCKS = 1024;
   // Blocks that a block number can name and that exist on the disk.
   localparam int LIM        = (NUM_BLOCKS < ID_SPACE) ? NUM_BLOCKS : ID_SPACE;
   localparam int LIM_W      = ID_W + 1;
   localparam int WORD_W     = 32;
   localparam int BIT_W      = $clog2(WORD_W);
   localparam int NUM_WORDS  = (LIM + WORD_W - 1) / WORD_W;
   localparam int WIDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int WSEL_W     = LIM_W - BIT_W;

   localparam logic [ID_W-1:0]  FIRST_DATA_RESET = ID_W'(34);
   localparam logic [LIM_W-1:0] LIM_C            = LIM_W'(LIM);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_FREE = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   typedef struct packed {
      logic             hit;
      logic [BIT_W-1:0] bit_idx;
   } scan_result_type;

   // Bitmap word that holds a given block number.
   function automatic logic [WIDX_W-1:0] word_of(input logic [LIM_W-1:0] blk);
      logic [LIM_W-1:0] s;
      s = blk >> BIT_W;
      return s[WIDX_W-1:0];
   endfunction

endpackage

[hdl/next_fit_block_allocator.sv]
// ----------------------------------------------------------------------------
// next_fit_block_allocator: next-fit bitmap block allocator
// Keeps a used/free bitmap of disk blocks in RAM and hands out free blocks
// starting from a next-fit pointer; releases blocks on request.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  req_     in         tuser: cmd; tdata[9:0]: free_id
//  rsp_     out        tuser: ok;  tdata[9:0]: block_id
//  csr_     in         wdata[9:0]: first_data_block (also reloads the pointer)
//
// A free request passes through the FREE and DONE states to its response.
// An allocate request reads the bitmap word by word in the SCAN state,
// at most one pass over all words plus one; the RAM read port sets the pace.
// Reset marks every block free through per-word valid bits, so no clearing
// pass is needed. One request is in flight at a time; a new one is accepted
// while the previous response still waits in the output register.
// ----------------------------------------------------------------------------
module next_fit_block_allocator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wen,
   input  logic [nfba_pkg::ID_W-1:0] csr_wdata,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [15:0]               req_tdata,   // [9:0] free_id
   input  logic                      req_tuser,   // [0] cmd
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [15:0]               rsp_tdata,   // [9:0] block_id
   output logic                      rsp_tuser    // [0] ok
);

   nfba_pkg::state_type           state_ff, state_in;
   logic                          phase_ff, phase_in;
   logic [nfba_pkg::WIDX_W-1:0]   widx_ff, widx_in;
   logic [nfba_pkg::ID_W-1:0]     ptr_ff, ptr_in;
   logic [nfba_pkg::ID_W-1:0]     fdb_ff, fdb_in;
   logic [nfba_pkg::ID_W-1:0]     res_id_ff, res_id_in;
   logic                          res_ok_ff, res_ok_in;
   logic [nfba_pkg::BIT_W-1:0]    fbit_ff, fbit_in;
   logic                          fhit_ff, fhit_in;
   logic [nfba_pkg::NUM_WORDS-1:0] wvalid_ff, wvalid_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [nfba_pkg::ID_W-1:0]     rsp_id_ff;
   logic                          rsp_ok_ff;
   logic                          rsp_load;

   logic [nfba_pkg::WIDX_W-1:0]   rd_addr;
   logic [nfba_pkg::WORD_W-1:0]   rd_data;
   logic                          wr_en;
   logic [nfba_pkg::WORD_W-1:0]   wr_data;

   logic [nfba_pkg::LIM_W-1:0]    ptr_ext, fdb_ext, fid_ext;
   logic [nfba_pkg::LIM_W-1:0]    r2_hi, range_lo, range_hi;
   logic                          r1_empty, r2_empty;
   logic [nfba_pkg::WIDX_W-1:0]   last_w;
   logic [nfba_pkg::WORD_W-1:0]   word_data, bit_sel, fbit_sel;
   logic [nfba_pkg::LIM_W-1:0]    blk, blk_next;
   logic                          slot_free;
   nfba_pkg::scan_result_type     scan;

   nfba_ram #(
      .WIDTH (nfba_pkg::WORD_W),
      .DEPTH (nfba_pkg::NUM_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (widx_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nfba_word_scan u_scan (
      .word_data (word_data),
      .word_idx  (widx_ff),
      .range_lo  (range_lo),
      .range_hi  (range_hi),
      .result    (scan)
   );

   assign ptr_ext  = nfba_pkg::LIM_W'(ptr_ff);
   assign fdb_ext  = nfba_pkg::LIM_W'(fdb_ff);
   assign fid_ext  = nfba_pkg::LIM_W'(req_tdata[nfba_pkg::ID_W-1:0]);
   assign r1_empty = ptr_ext >= nfba_pkg::LIM_C;
   assign r2_hi    = r1_empty ? nfba_pkg::LIM_C : ptr_ext;
   assign r2_empty = fdb_ext >= r2_hi;
   assign range_lo = phase_ff ? fdb_ext : ptr_ext;
   assign range_hi = phase_ff ? r2_hi : nfba_pkg::LIM_C;
   assign last_w   = nfba_pkg::word_of(range_hi - nfba_pkg::LIM_W'(1));

   // A word never written since reset reads as all free.
   assign word_data = wvalid_ff[widx_ff] ? rd_data : '0;
   assign bit_sel   = nfba_pkg::WORD_W'(1) << scan.bit_idx;
   assign fbit_sel  = nfba_pkg::WORD_W'(1) << fbit_ff;
   assign blk       = (nfba_pkg::LIM_W'(widx_ff) << nfba_pkg::BIT_W)
                      | nfba_pkg::LIM_W'(scan.bit_idx);
   assign blk_next  = blk + nfba_pkg::LIM_W'(1);
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      widx_in      = widx_ff;
      ptr_in       = ptr_ff;
      fdb_in       = fdb_ff;
      res_id_in    = res_id_ff;
      res_ok_in    = res_ok_ff;
      fbit_in      = fbit_ff;
      fhit_in      = fhit_ff;
      wvalid_in    = wvalid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_load     = 1'b0;
      rd_addr      = widx_ff;
      wr_en        = 1'b0;
      wr_data      = word_data | bit_sel;

      if (csr_wen) begin
         fdb_in = csr_wdata;
         ptr_in = csr_wdata;
      end

      unique case (state_ff)
         nfba_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == nfba_pkg::CMD_FREE) begin
                  fhit_in   = fid_ext < nfba_pkg::LIM_C;
                  fbit_in   = fid_ext[nfba_pkg::BIT_W-1:0];
                  widx_in   = nfba_pkg::word_of(fid_ext);
                  rd_addr   = nfba_pkg::word_of(fid_ext);
                  res_id_in = '0;
                  res_ok_in = 1'b1;
                  state_in  = nfba_pkg::ST_FREE;
               end else if (!r1_empty) begin
                  phase_in = 1'b0;
                  widx_in  = nfba_pkg::word_of(ptr_ext);
                  rd_addr  = nfba_pkg::word_of(ptr_ext);
                  state_in = nfba_pkg::ST_SCAN;
               end else if (!r2_empty) begin
                  phase_in = 1'b1;
                  widx_in  = nfba_pkg::word_of(fdb_ext);
                  rd_addr  = nfba_pkg::word_of(fdb_ext);
                  state_in = nfba_pkg::ST_SCAN;
               end else begin
                  res_id_in = '0;
                  res_ok_in = 1'b0;
                  state_in  = nfba_pkg::ST_DONE;
               end
            end
         end
         nfba_pkg::ST_SCAN: begin
            if (scan.hit) begin
               wr_en              = 1'b1;
               wvalid_in[widx_ff] = 1'b1;
               res_id_in          = blk[nfba_pkg::ID_W-1:0];
               res_ok_in          = 1'b1;
               ptr_in             = (blk_next == nfba_pkg::LIM_C) ? fdb_ff
                                    : blk_next[nfba_pkg::ID_W-1:0];
               state_in           = nfba_pkg::ST_DONE;
            end else if (widx_ff == last_w) begin
               if (!phase_ff && !r2_empty) begin
                  // Nothing from the pointer upwards: wrap to the data area.
                  phase_in = 1'b1;
                  widx_in  = nfba_pkg::word_of(fdb_ext);
                  rd_addr  = nfba_pkg::word_of(fdb_ext);
               end else begin
                  res_id_in = '0;
                  res_ok_in = 1'b0;
                  state_in  = nfba_pkg::ST_DONE;
               end
            end else begin
               widx_in = widx_ff + nfba_pkg::WIDX_W'(1);
               rd_addr = widx_ff + nfba_pkg::WIDX_W'(1);
            end
         end
         nfba_pkg::ST_FREE: begin
            wr_data = word_data & ~fbit_sel;
            if (fhit_ff) begin
               wr_en              = 1'b1;
               wvalid_in[widx_ff] = 1'b1;
            end
            state_in = nfba_pkg::ST_DONE;
         end
         nfba_pkg::ST_DONE: begin
            if (slot_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = nfba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nfba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nfba_pkg::ST_IDLE;
         ptr_ff       <= nfba_pkg::FIRST_DATA_RESET;
         fdb_ff       <= nfba_pkg::FIRST_DATA_RESET;
         wvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         fdb_ff       <= fdb_in;
         wvalid_ff    <= wvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff  <= phase_in;
      widx_ff   <= widx_in;
      res_id_ff <= res_id_in;
      res_ok_ff <= res_ok_in;
      fbit_ff   <= fbit_in;
      fhit_ff   <= fhit_in;
      if (rsp_load) begin
         rsp_id_ff <= res_id_ff;
         rsp_ok_ff <= res_ok_ff;
      end
   end

   assign req_tready = state_ff == nfba_pkg::ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 16'(rsp_id_ff);
   assign rsp_tuser  = rsp_ok_ff;

endmodule

[hdl/nfba_ram.sv]
// ----------------------------------------------------------------------------
// nfba_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module nfba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/nfba_word_scan.sv]
// ----------------------------------------------------------------------------
// nfba_word_scan: free-bit search within one bitmap word
// Masks the word to the block range [range_lo, range_hi) and finds the
// lowest free block in it.
// ----------------------------------------------------------------------------
module nfba_word_scan (
   input  logic [nfba_pkg::WORD_W-1:0]  word_data,
   input  logic [nfba_pkg::WIDX_W-1:0]  word_idx,
   input  logic [nfba_pkg::LIM_W-1:0]   range_lo,
   input  logic [nfba_pkg::LIM_W-1:0]   range_hi,
   output nfba_pkg::scan_result_type    result
);

   logic [nfba_pkg::WSEL_W-1:0] w_sel;
   logic [nfba_pkg::WSEL_W-1:0] lo_w;
   logic [nfba_pkg::WSEL_W-1:0] hi_w;
   logic [nfba_pkg::WORD_W-1:0] lo_mask;
   logic [nfba_pkg::WORD_W-1:0] hi_mask;
   logic [nfba_pkg::WORD_W-1:0] cand;
   logic [nfba_pkg::WORD_W-1:0] lowest;
   logic [nfba_pkg::BIT_W-1:0]  idx;

   assign w_sel = nfba_pkg::WSEL_W'(word_idx);
   assign lo_w  = range_lo[nfba_pkg::LIM_W-1:nfba_pkg::BIT_W];
   assign hi_w  = range_hi[nfba_pkg::LIM_W-1:nfba_pkg::BIT_W];

   always_comb begin
      if (w_sel == lo_w) begin
         lo_mask = {nfba_pkg::WORD_W{1'b1}} << range_lo[nfba_pkg::BIT_W-1:0];
      end else if (w_sel > lo_w) begin
         lo_mask = {nfba_pkg::WORD_W{1'b1}};
      end else begin
         lo_mask = '0;
      end
      if (w_sel == hi_w) begin
         hi_mask = ~({nfba_pkg::WORD_W{1'b1}} << range_hi[nfba_pkg::BIT_W-1:0]);
      end else if (w_sel < hi_w) begin
         hi_mask = {nfba_pkg::WORD_W{1'b1}};
      end else begin
         hi_mask = '0;
      end
   end

   assign cand   = ~word_data & lo_mask & hi_mask;
   // Isolate the lowest candidate so that the encoder sees a single bit.
   assign lowest = cand & (~cand + nfba_pkg::WORD_W'(1));

   always_comb begin
      idx = '0;
      for (int i = 0; i < nfba_pkg::WORD_W; i++) begin
         if (lowest[i]) begin
            idx = idx | nfba_pkg::BIT_W'(i);
         end
      end
   end

   assign result.hit     = |cand;
   assign result.bit_idx = idx;

endmodule
